// ===== design/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants of the utf-8 to codepoint decoder
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned LEFT_W = 2;
	localparam int unsigned CONT_W = 6;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = CP_W'(24'h00FFFD);

	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
	localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
	localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
	localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_string;
	} byte_item_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            bad_lead;
		logic            cut_short;
		logic            final_item;
	} cp_item_t;

	typedef struct packed {
		logic advance;
		logic emit;
	} core_ctl_t;

endpackage

`default_nettype wire

// ===== design/utf8d_ifs.sv =====
// ----------------------------------------------------------------------------
// utf8d channel interfaces
// byte channel in, codepoint channel out, both valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8d_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        bad_lead;
	logic        cut_short;
	logic        final_item;

	modport source (
		output valid, output code_point, output bad_lead, output cut_short,
		output final_item, input ready
	);
	modport sink (
		input valid, input code_point, input bad_lead, input cut_short,
		input final_item, output ready
	);
endinterface

`default_nettype wire

// ===== design/utf8d_in_stage.sv =====
// ----------------------------------------------------------------------------
// utf8d_in_stage
// input register, takes a new byte when it is empty or the held one moves on
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_in_stage
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire byte_item_t in_item,
	output logic            in_ready,
	input  wire logic       advance,
	output logic            valid_s1,
	output byte_item_t      item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== design/utf8d_core.sv =====
// ----------------------------------------------------------------------------
// utf8d_core
// lead decode, continuation merge and truncation repair with sequence state
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_core
	import utf8d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       valid_s1,
	input  wire byte_item_t item_s1,
	input  wire logic       out_free,
	output core_ctl_t       ctl,
	output cp_item_t        result
);

	logic [CP_W-1:0]   partial_q;
	logic [LEFT_W-1:0] bytes_left_q;
	logic [CP_W-1:0]   partial_d;
	logic [LEFT_W-1:0] bytes_left_d;
	logic              emit;
	logic [BYTE_W-1:0] b;
	logic              eos;

	assign b   = item_s1.data_byte;
	assign eos = item_s1.end_of_string;

	always_comb begin
		partial_d    = partial_q;
		bytes_left_d = bytes_left_q;
		emit         = 1'b0;
		result       = '0;
		result.final_item = eos;

		if (bytes_left_q == LEFT_NONE) begin
			if (!b[BYTE_W-1]) begin
				emit = 1'b1;
				result.code_point = CP_W'(b);
			end else if (b[7:5] == LEAD2_TAG) begin
				partial_d    = CP_W'(b[4:0]);
				bytes_left_d = LEFT_ONE;
			end else if (b[7:4] == LEAD3_TAG) begin
				partial_d    = CP_W'(b[3:0]);
				bytes_left_d = LEFT_TWO;
			end else if (b[7:3] == LEAD4_TAG) begin
				partial_d    = CP_W'(b[2:0]);
				bytes_left_d = LEFT_THREE;
			end else begin
				emit = 1'b1;
				result.code_point = REPLACEMENT_CP;
				result.bad_lead   = 1'b1;
			end
		end else begin
			partial_d    = {partial_q[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
			bytes_left_d = bytes_left_q - LEFT_ONE;
			if (bytes_left_d == LEFT_NONE) begin
				emit = 1'b1;
				result.code_point = partial_d;
				partial_d = '0;
			end
		end

		// string ended inside a sequence: missing bits are zero
		if (!emit && eos) begin
			emit = 1'b1;
			result.cut_short  = 1'b1;
			result.final_item = 1'b1;
			case (bytes_left_d)
				LEFT_ONE:   result.code_point = {partial_d[CP_W-7:0], 6'b0};
				LEFT_TWO:   result.code_point = {partial_d[CP_W-13:0], 12'b0};
				LEFT_THREE: result.code_point = {partial_d[CP_W-19:0], 18'b0};
				default:    result.code_point = partial_d;
			endcase
			partial_d    = '0;
			bytes_left_d = LEFT_NONE;
		end
	end

	assign ctl.emit    = valid_s1 && emit;
	assign ctl.advance = valid_s1 && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			bytes_left_q <= LEFT_NONE;
		end else if (ctl.advance) begin
			partial_q    <= partial_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		bytes_left_q == LEFT_NONE |-> partial_q == '0)
		else $error("accumulator not clear between sequences");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance && !ctl.emit |=> bytes_left_q != LEFT_NONE)
		else $error("silent item left no sequence open");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance && ctl.emit && result.cut_short |=> bytes_left_q == LEFT_NONE)
		else $error("truncated sequence not closed");

	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && result.bad_lead |-> !result.cut_short && bytes_left_q == LEFT_NONE)
		else $error("bad lead flagged inside a sequence");

endmodule

`default_nettype wire

// ===== design/utf8d_out_stage.sv =====
// ----------------------------------------------------------------------------
// utf8d_out_stage
// result register, holds one codepoint item until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_out_stage
	import utf8d_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire core_ctl_t ctl,
	input  wire cp_item_t  result,
	output logic           out_free,
	output logic           out_valid,
	input  wire logic      out_ready,
	output cp_item_t       out_item
);

	logic     valid_s2;
	cp_item_t item_s2;
	logic     load;

	assign out_free  = !valid_s2 || out_ready;
	assign load      = ctl.advance && ctl.emit;
	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s2 <= result;
		end
	end

endmodule

`default_nettype wire

// ===== design/utf8_to_codepoint_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// decodes a utf-8 byte stream into 21-bit codepoints
//
// bytes: one raw byte per item with an end_of_string flag on the last byte
// codes: one codepoint item per finished sequence, lone ascii byte, invalid
//   lead (0xfffd, bad_lead) or string cut inside a sequence (cut_short)
// continuation bytes that do not finish a sequence give no item
// throughput: one byte per cycle while the receiver does not stall; the
//   decode between the input and result registers is combinational
// a stalled receiver holds the result register; a byte behind it that gives
//   an item waits in the input register and bytes.ready drops until the
//   result is taken
// reset clears both registers and the sequence state
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_codepoint_decoder
	import utf8d_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	utf8d_byte_if.sink  bytes,
	utf8d_cp_if.source  codes
);

	byte_item_t in_item;
	byte_item_t item_s1;
	logic       valid_s1;
	core_ctl_t  ctl;
	cp_item_t   result;
	cp_item_t   out_item;
	logic       out_free;

	assign in_item.data_byte     = bytes.data_byte;
	assign in_item.end_of_string = bytes.end_of_string;

	utf8d_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bytes.valid),
		.in_item  (in_item),
		.in_ready (bytes.ready),
		.advance  (ctl.advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	utf8d_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.ctl      (ctl),
		.result   (result)
	);

	utf8d_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_free  (out_free),
		.out_valid (codes.valid),
		.out_ready (codes.ready),
		.out_item  (out_item)
	);

	assign codes.code_point = out_item.code_point;
	assign codes.bad_lead   = out_item.bad_lead;
	assign codes.cut_short  = out_item.cut_short;
	assign codes.final_item = out_item.final_item;

endmodule

`default_nettype wire
